@@ design/dch_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dch_pkg
// shared constants for the dominant color histogram core
// ----------------------------------------------------------------------------
package dch_pkg;

  // width of one color or alpha channel
  localparam int CH_W = 8;

  // width of the count field on the result port
  localparam int OUT_CW = 24;

  // largest count the result port can carry
  localparam logic [OUT_CW-1:0] OUT_COUNT_MAX = {OUT_CW{1'b1}};

  // alpha threshold after reset
  localparam logic [CH_W-1:0] ALPHA_RESET = 8'd128;

endpackage

@@ design/dch_bin_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dch_bin_ram
// simple dual-port bin memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dch_bin_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // read returns the old entry when the same address is written at that edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/dominant_color_histogram_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dominant_color_histogram_core
// most frequent quantized color of an image, from a histogram kept in memory
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on the input channel (in_valid / in_ready), one item per
//   cycle while an image streams in. a pixel whose alpha is above the
//   threshold bumps its bin through a read-modify-write of the bin memory
//   (a read stage, then modify and write); a back-to-back hit on the same
//   bin is forwarded from the write stage. the item with last_pixel set
//   closes the image. after the closing item the core passes through a
//   drain state, then scans one bin a cycle over all 2^(3*(8-QUANT_SHIFT))
//   bins (32768 by default), reading and zeroing each, then compares the
//   final bin, and the result then loads into the output register.
//   in_ready is low during that scan.
//   the result sits in its output register (out_valid / out_ready) and the
//   next image may start streaming while it waits; a second result only
//   waits for the first to be taken when it is ready to load.
//   alpha_threshold is written over cfg_valid / cfg_data, always ready.
//   reset (rst, synchronous) runs a clearing pass over every bin, one bin a
//   cycle, with in_ready low; configuration is taken then.
// ----------------------------------------------------------------------------
module dominant_color_histogram_core
  import dch_pkg::*;
#(
  parameter int QUANT_SHIFT = 3,
  parameter int COUNT_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst,

  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CH_W-1:0]   cfg_data,

  // pixel channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   pixel_alpha,
  input  logic [CH_W-1:0]   pixel_red,
  input  logic [CH_W-1:0]   pixel_green,
  input  logic [CH_W-1:0]   pixel_blue,
  input  logic              last_pixel,

  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   mode_red,
  output logic [CH_W-1:0]   mode_green,
  output logic [CH_W-1:0]   mode_blue,
  output logic [OUT_CW-1:0] mode_count,
  output logic              any_counted
);

  localparam int CH_BITS = CH_W - QUANT_SHIFT;
  localparam int BIN_W   = 3 * CH_BITS;
  localparam int WIDE_W  = (COUNT_BITS > OUT_CW) ? COUNT_BITS : OUT_CW;

  typedef enum logic [2:0] {
    ST_CLEAR,     // zeroing pass after reset
    ST_RUN,       // taking pixels
    ST_DRAIN,     // last pixel finishes its bin update
    ST_SCAN,      // read and zero one bin a cycle
    ST_SCAN_END,  // compare of the final bin
    ST_OUT        // load the result register
  } state_t;

  state_t state;

  logic [CH_W-1:0]       alpha_threshold;
  logic [BIN_W-1:0]      addr;          // sweep address for clear and scan

  // update pipeline: read stage, then modify and write
  logic                  p_valid;
  logic [BIN_W-1:0]      p_idx;
  logic                  w_valid;       // last write, for same-bin forwarding
  logic [BIN_W-1:0]      w_idx;
  logic [COUNT_BITS-1:0] w_data;

  // scan compare stage
  logic                  s_valid;
  logic [BIN_W-1:0]      s_idx;
  logic [COUNT_BITS-1:0] best_count;
  logic [BIN_W-1:0]      best_bin;

  logic                  accept;
  logic                  counted;
  logic [BIN_W-1:0]      idx_in;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] inc_count;
  logic                  ram_we;
  logic [BIN_W-1:0]      ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [BIN_W-1:0]      ram_raddr;
  logic [WIDE_W-1:0]     count_wide;
  logic [OUT_CW-1:0]     count_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_RUN);
  assign accept    = in_valid && in_ready;
  assign counted   = accept && (pixel_alpha > alpha_threshold);

  // bin index: red most significant
  assign idx_in = {pixel_red[CH_W-1:QUANT_SHIFT],
                   pixel_green[CH_W-1:QUANT_SHIFT],
                   pixel_blue[CH_W-1:QUANT_SHIFT]};

  // the write that lands at the read edge is not seen by the read
  assign old_count = (w_valid && (w_idx == p_idx)) ? w_data : rd_data;
  assign inc_count = (&old_count) ? old_count : old_count + COUNT_BITS'(1);

  // one write port: pixel updates, or zeros during clear and scan
  always_comb begin
    ram_we    = p_valid;
    ram_waddr = p_idx;
    ram_wdata = inc_count;
    if ((state == ST_CLEAR) || (state == ST_SCAN)) begin
      ram_we    = 1'b1;
      ram_waddr = addr;
      ram_wdata = '0;
    end
  end

  assign ram_raddr = (state == ST_SCAN) ? addr : idx_in;

  dch_bin_ram #(
    .ADDR_W (BIN_W),
    .DATA_W (COUNT_BITS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // result count saturates to the port width
  assign count_wide = WIDE_W'(best_count);
  assign count_sat  = (count_wide > WIDE_W'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                            : OUT_CW'(count_wide);

  // datapath registers of the update and scan stages
  always_ff @(posedge clk) begin
    p_idx  <= idx_in;
    w_idx  <= p_idx;
    w_data <= inc_count;
    s_idx  <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      alpha_threshold <= ALPHA_RESET;
      addr            <= '0;
      p_valid         <= 1'b0;
      w_valid         <= 1'b0;
      s_valid         <= 1'b0;
      best_count      <= '0;
      best_bin        <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        alpha_threshold <= cfg_data;
      end

      p_valid <= counted;
      w_valid <= p_valid;
      s_valid <= (state == ST_SCAN);

      // running maximum, strict compare keeps the lowest bin on a tie
      if (s_valid && (rd_data > best_count)) begin
        best_count <= rd_data;
        best_bin   <= s_idx;
      end

      // in ST_OUT a taken result is replaced by the new load below
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          addr <= addr + BIN_W'(1);
          if (&addr) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (accept && last_pixel) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          best_count <= '0;
          best_bin   <= '0;
          addr       <= '0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          addr <= addr + BIN_W'(1);
          if (&addr) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            mode_red    <= CH_W'(best_bin[3*CH_BITS-1:2*CH_BITS]) << QUANT_SHIFT;
            mode_green  <= CH_W'(best_bin[2*CH_BITS-1:CH_BITS]) << QUANT_SHIFT;
            mode_blue   <= CH_W'(best_bin[CH_BITS-1:0]) << QUANT_SHIFT;
            mode_count  <= count_sat;
            any_counted <= (best_count != '0);
            state       <= ST_RUN;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

@@ tb/tb_dominant_color_histogram_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dominant_color_histogram_core
// self-checking bench for the dominant color histogram core
// ----------------------------------------------------------------------------
// pixels stream in over valid/ready, images are closed by last_pixel. a
// bench-side histogram keyed by quantized bin tracks every counted pixel and,
// on the closing pixel, scans for the first bin holding the highest count.
// each result taken from the core is compared field by field with the oldest
// pending prediction. a short directed table (corners, ties, alpha at the
// threshold, same-bin bursts, empty images) is followed by random images
// built from small palettes plus noise, with random idling on both sides and
// threshold writes between images.
// ----------------------------------------------------------------------------
module tb_dominant_color_histogram_core;
  import dch_pkg::*;

  // core configuration as instantiated
  localparam int          QSHIFT     = 3;
  localparam int          COUNT_BITS = 24;
  localparam int unsigned COUNT_MAX  = (1 << COUNT_BITS) - 1;

  // run shape
  localparam int RAND_ITEMS   = 830;   // pixels in the random part
  localparam int MAX_IMAGES   = 45;    // each image costs a full bin scan
  localparam int SETTLE       = 8;     // pixel pipeline drain before a write
  localparam int END_SETTLE   = 64;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [OUT_CW-1:0] count;
    logic              any;
  } mode_t;

  // one row of the directed table: optional threshold write, then a pixel;
  // typed rows carry the result expected from the closing pixel
  typedef struct packed {
    logic            set_cfg;
    logic [CH_W-1:0] cfg_val;
    pixel_t          px;
    logic            typed;
    mode_t           want;
  } dir_row_t;

  localparam mode_t BLACK   = '0;
  localparam int    N_ROWS  = 20;

  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    // empty image: alpha equal to the reset threshold is ignored
    '{1'b0, 8'd0,   '{8'd128, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, BLACK},
    // top corner of the color cube
    '{1'b0, 8'd0,   '{8'd255, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1,
      '{8'd248, 8'd248, 8'd248, 24'd1, 1'b1}},
    // bottom corner, alpha just above the threshold
    '{1'b0, 8'd0,   '{8'd129, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 24'd1, 1'b1}},
    // two bins tied at two hits, the lower index must win
    '{1'b0, 8'd0,   '{8'd255, 8'hc7, 8'h0a, 8'h13, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd200, 8'h10, 8'h28, 8'h07, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd0,   8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd128, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd130, 8'hc0, 8'h08, 8'h10, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd255, 8'h17, 8'h2f, 8'h00, 1'b1}, 1'b0, BLACK},
    // back-to-back hits on one bin, then a hit two items apart
    '{1'b0, 8'd0,   '{8'd255, 8'h55, 8'haa, 8'h33, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd254, 8'h50, 8'haf, 8'h37, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd253, 8'h57, 8'ha8, 8'h30, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd255, 8'h80, 8'h80, 8'h80, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd255, 8'h55, 8'haa, 8'h33, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd255, 8'h80, 8'h80, 8'h80, 1'b1}, 1'b0, BLACK},
    // highest threshold: nothing can pass, result is black
    '{1'b1, 8'd255, '{8'd255, 8'hff, 8'h00, 8'hff, 1'b1}, 1'b1, BLACK},
    // lowest threshold: only alpha zero is dropped
    '{1'b1, 8'd0,   '{8'd0,   8'h12, 8'h34, 8'h56, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd1,   8'h12, 8'h34, 8'h56, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd1,   8'hff, 8'hff, 8'hff, 1'b0}, 1'b0, BLACK},
    '{1'b0, 8'd0,   '{8'd1,   8'hff, 8'hff, 8'hff, 1'b1}, 1'b0, BLACK}
  };

  // dut signals; the bench-driven inputs are known from time zero
  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CH_W-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [CH_W-1:0] pixel_alpha = '0;
  logic [CH_W-1:0] pixel_red = '0;
  logic [CH_W-1:0] pixel_green = '0;
  logic [CH_W-1:0] pixel_blue = '0;
  logic            last_pixel = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [CH_W-1:0]   mode_red;
  logic [CH_W-1:0]   mode_green;
  logic [CH_W-1:0]   mode_blue;
  logic [OUT_CW-1:0] mode_count;
  logic              any_counted;

  // bench-side histogram and threshold
  int unsigned     bin_tally [int unsigned];
  logic [CH_W-1:0] alpha_limit = ALPHA_RESET;

  // predicted results, oldest first
  mode_t pending_modes [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  pixels_sent = 0;
  int  pixels_counted = 0;
  int  images_sent = 0;
  int  cfg_writes = 0;
  int  rx_hold = 0;
  bit  calm = 1'b0;      // no idling on either side once set

  dominant_color_histogram_core #(
    .QUANT_SHIFT (QSHIFT),
    .COUNT_BITS  (COUNT_BITS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_alpha (pixel_alpha),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .last_pixel  (last_pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mode_red    (mode_red),
    .mode_green  (mode_green),
    .mode_blue   (mode_blue),
    .mode_count  (mode_count),
    .any_counted (any_counted)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // count one accepted pixel; on the closing pixel scan the bins in
  // ascending order, keep the first highest count and clear the histogram
  function automatic bit tally_pixel(input pixel_t px, output mode_t res);
    logic [14:0] bin;
    logic [14:0] win;
    int unsigned top;
    res = '0;
    if (px.alpha > alpha_limit) begin
      bin = {px.red[7:QSHIFT], px.green[7:QSHIFT], px.blue[7:QSHIFT]};
      if (!bin_tally.exists(bin)) bin_tally[bin] = 0;
      if (bin_tally[bin] < COUNT_MAX) bin_tally[bin] = bin_tally[bin] + 1;
    end
    if (!px.last) return 1'b0;
    top = 0;
    win = '0;
    foreach (bin_tally[k]) begin
      if (bin_tally[k] > top) begin
        top = bin_tally[k];
        win = k[14:0];
      end
    end
    bin_tally.delete();
    res.red   = {win[14:10], 3'b000};
    res.green = {win[9:5], 3'b000};
    res.blue  = {win[4:0], 3'b000};
    res.count = (top > OUT_COUNT_MAX) ? OUT_COUNT_MAX : top[OUT_CW-1:0];
    res.any   = (top != 0);
    return 1'b1;
  endfunction

  // offer one pixel, with an optional idle burst first; in_valid stays high
  // on return so the next item can follow without a bubble
  task automatic push_pixel(input pixel_t px, input logic typed, input mode_t want);
    mode_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_alpha <= px.alpha;
    pixel_red   <= px.red;
    pixel_green <= px.green;
    pixel_blue  <= px.blue;
    last_pixel  <= px.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    pixels_sent++;
    if (px.alpha > alpha_limit) pixels_counted++;
    if (px.last) images_sent++;
    if (tally_pixel(px, res)) pending_modes.push_back(typed ? want : res);
  endtask

  // hold the sender until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // threshold writes only happen with the core idle
  task automatic set_threshold(input logic [CH_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    alpha_limit = val;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall bursts on out_ready
  always @(posedge clk) begin
    if (rx_hold > 0) rx_hold = rx_hold - 1;
    else if (!calm && $urandom_range(0, 11) == 0) rx_hold = $urandom_range(1, 17);
    out_ready <= (rx_hold == 0);
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin
    mode_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_modes.size() == 0) begin
        $display("%0t ns: result with nothing expected (rgb %0d %0d %0d count %0d)",
                 $time, mode_red, mode_green, mode_blue, mode_count);
        mismatches++;
      end else begin
        want = pending_modes.pop_front();
        check_field("mode_red",    want.red,   mode_red);
        check_field("mode_green",  want.green, mode_green);
        check_field("mode_blue",   want.blue,  mode_blue);
        check_field("mode_count",  want.count, mode_count);
        check_field("any_counted", want.any,   any_counted);
        results_seen++;
      end
    end
  end

  // main sequence
  initial begin
    pixel_t      px;
    logic [14:0] pal [4];
    int          rand_items;
    int          rand_images;
    int          len;
    int          npal;
    int          thr;
    int          pick;

    rand_items  = 0;
    rand_images = 0;

    // reset once; the core then clears its bins with in_ready low
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      if (DIR_ROWS[i].set_cfg) set_threshold(DIR_ROWS[i].cfg_val);
      push_pixel(DIR_ROWS[i].px, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    // random images: a few dominant bins with jittered low bits, some noise,
    // some pixels at or below the threshold
    while (rand_items < RAND_ITEMS && rand_images < MAX_IMAGES) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) set_threshold(8'd0);
      else if (pick == 1) set_threshold(8'd255);
      else if (pick < 5) set_threshold(8'($urandom_range(0, 255)));
      else if (pick == 5) drain_results();

      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      npal = $urandom_range(1, 4);
      foreach (pal[p]) pal[p] = 15'($urandom_range(0, 32767));
      thr = int'(alpha_limit);

      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise pixel, any value
          px.alpha = 8'($urandom_range(0, 255));
          px.red   = 8'($urandom_range(0, 255));
          px.green = 8'($urandom_range(0, 255));
          px.blue  = 8'($urandom_range(0, 255));
        end else begin
          pick     = $urandom_range(0, npal - 1);
          px.red   = {pal[pick][14:10], 3'($urandom_range(0, 7))};
          px.green = {pal[pick][9:5], 3'($urandom_range(0, 7))};
          px.blue  = {pal[pick][4:0], 3'($urandom_range(0, 7))};
          if (thr == 255 || $urandom_range(0, 6) == 0)
            px.alpha = ($urandom_range(0, 2) == 0) ? 8'(thr) : 8'($urandom_range(0, thr));
          else
            px.alpha = 8'($urandom_range(thr + 1, 255));
        end
        px.last = (j == len - 1);
        rand_items++;
        push_pixel(px, 1'b0, BLACK);
        // the tail of the run goes without idling
        if (rand_items >= RAND_ITEMS * 17 / 20) calm = 1'b1;
      end
      rand_images++;
    end

    // wait out the last scan and a little more
    in_valid <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    $display("covered %0d pixels (%0d past the alpha test) in %0d images, %0d results checked",
             pixels_sent, pixels_counted, images_sent, results_seen);
    $display("threshold written %0d times, both extremes included", cfg_writes);
    if (mismatches == 0) begin
      $display("** dominant_color_histogram_core: PASSED **");
    end else begin
      $display("** dominant_color_histogram_core: FAILED **");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run (at most 52 image scans and the reset clear)
  initial begin
    #100_000_000;
    $display("timeout with %0d results still pending", pending_modes.size());
    $display("** dominant_color_histogram_core: FAILED **");
    $finish;
  end

endmodule
